/* rtl/core/mma_pkg.sv */
package mma_pkg;

   // Field widths of the request and response beats
   localparam int ACTION_W = 2;
   localparam int ROW_W    = 10;
   localparam int INNER_W  = 10;
   localparam int COL_W    = 3;
   localparam int VALUE_W  = 32;

   // Packed request beat: row, inner, col, value from bit 0 up, padded to bytes
   localparam int REQ_FIELDS_W = ROW_W + INNER_W + COL_W + VALUE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int ROW_LSB      = 0;
   localparam int INNER_LSB    = ROW_LSB + ROW_W;
   localparam int COL_LSB      = INNER_LSB + INNER_W;
   localparam int VALUE_LSB    = COL_LSB + COL_W;

   localparam int RSP_DATA_W = VALUE_W;

   // Size registers
   localparam int ROWS_CFG_W  = 11;
   localparam int INNER_CFG_W = 11;
   localparam int COLS_CFG_W  = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [ROWS_CFG_W-1:0]  ROWS_RESET  = ROWS_CFG_W'(1024);
   localparam logic [INNER_CFG_W-1:0] INNER_RESET = INNER_CFG_W'(1024);
   localparam logic [COLS_CFG_W-1:0]  COLS_RESET  = COLS_CFG_W'(8);

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_USED  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_USED = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_USED  = CSR_INDEX_W'(2);

   // Default array limits
   localparam int MAX_ROWS_DEF  = 1024;
   localparam int MAX_INNER_DEF = 1024;
   localparam int MAX_COLS_DEF  = 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_S   = 2'd0,
      ACT_STREAM_A = 2'd1,
      ACT_LOAD_ACC = 2'd2,
      ACT_READ_ACC = 2'd3
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_MAC   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

endpackage

/* rtl/core/mma_ram.sv */
module mma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/matrix_mul_accumulate_top.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tuser: action; tdata: row, inner, col, value
// rsp       out        rsp_tvalid/rsp_tready  tuser: bad_index; tdata: read_value
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One item at a time. A load writes its memory in EXEC; a read and an A element
// also pass DRAIN. An A element takes one read-modify-write per effective column
// through the accumulator's single write port, with a multiplier stage in between.
// Reset clears the control state and sets the size registers to the default array
// limits; the S and accumulator memories are not cleared.
// A finished response waits in its output register; the next request is taken
// meanwhile, and a second response holds the block until the first is taken.
module matrix_mul_accumulate_top #(
   parameter int MAX_ROWS  = mma_pkg::MAX_ROWS_DEF,
   parameter int MAX_INNER = mma_pkg::MAX_INNER_DEF,
   parameter int MAX_COLS  = mma_pkg::MAX_COLS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // row [9:0], inner [19:10], col [22:20], value [54:23], zero pad
   input  logic [mma_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action [1:0]
   input  logic [mma_pkg::ACTION_W-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value [31:0]
   output logic [mma_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // bad_index [0]
   output logic [0:0]                       rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mma_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mma_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int SDepth   = MAX_COLS * MAX_INNER;
   localparam int AccDepth = MAX_ROWS * MAX_COLS;
   localparam int SAW      = (SDepth > 1) ? $clog2(SDepth) : 1;
   localparam int AccAW    = (AccDepth > 1) ? $clog2(AccDepth) : 1;
   localparam int CntW     = mma_pkg::COLS_CFG_W;
   localparam logic [CntW-1:0] ColsCap = CntW'((MAX_COLS > 15) ? 15 : MAX_COLS);

   // Size registers
   logic [mma_pkg::ROWS_CFG_W-1:0]  rows_used_ff;
   logic [mma_pkg::INNER_CFG_W-1:0] inner_used_ff;
   logic [mma_pkg::COLS_CFG_W-1:0]  cols_used_ff;

   // Item under work
   mma_pkg::state_type              state_ff, state_in;
   mma_pkg::action_type             action_ff;
   logic [mma_pkg::ROW_W-1:0]       row_ff;
   logic [mma_pkg::INNER_W-1:0]     inner_ff;
   logic [mma_pkg::COL_W-1:0]       col_ff;
   logic [mma_pkg::VALUE_W-1:0]     value_ff;
   logic                            bad_ff, bad_in;
   logic                            rd_pend_ff;
   logic [mma_pkg::VALUE_W-1:0]     rd_value_ff;

   // Column loop
   logic [CntW-1:0]                 cnt_ff;
   logic [CntW-1:0]                 ncols;
   logic                            p1_valid_ff;
   logic [CntW-1:0]                 p1_col_ff;
   logic                            p2_valid_ff;
   logic [CntW-1:0]                 p2_col_ff;
   logic [mma_pkg::VALUE_W-1:0]     p2_prod_ff;
   logic [mma_pkg::VALUE_W-1:0]     p2_acc_ff;

   // Response register
   logic                            rsp_valid_ff;
   logic [mma_pkg::VALUE_W-1:0]     rsp_data_ff;
   logic                            rsp_bad_ff;
   logic                            rsp_load;

   // Memory ports
   logic                            s_we;
   logic [SAW-1:0]                  s_wr_addr;
   logic                            s_re;
   logic [SAW-1:0]                  s_rd_addr;
   logic [mma_pkg::VALUE_W-1:0]     s_rd_data;
   logic                            acc_we;
   logic [AccAW-1:0]                acc_wr_addr;
   logic [mma_pkg::VALUE_W-1:0]     acc_wr_data;
   logic                            acc_re;
   logic [AccAW-1:0]                acc_rd_addr;
   logic [mma_pkg::VALUE_W-1:0]     acc_rd_data;

   // Request decode
   mma_pkg::action_type             req_action;
   logic [mma_pkg::ROW_W-1:0]       req_row;
   logic [mma_pkg::INNER_W-1:0]     req_inner;
   logic [mma_pkg::COL_W-1:0]       req_col;
   logic                            row_ok, inner_ok, col_ok;
   logic                            req_fire;

   assign req_action = mma_pkg::action_type'(req_tuser);
   assign req_row    = req_tdata[mma_pkg::ROW_LSB +: mma_pkg::ROW_W];
   assign req_inner  = req_tdata[mma_pkg::INNER_LSB +: mma_pkg::INNER_W];
   assign req_col    = req_tdata[mma_pkg::COL_LSB +: mma_pkg::COL_W];

   assign row_ok   = (mma_pkg::ROWS_CFG_W'(req_row) < rows_used_ff)
                     && (32'(req_row) < MAX_ROWS);
   assign inner_ok = (mma_pkg::INNER_CFG_W'(req_inner) < inner_used_ff)
                     && (32'(req_inner) < MAX_INNER);
   assign col_ok   = (mma_pkg::COLS_CFG_W'(req_col) < cols_used_ff)
                     && (32'(req_col) < MAX_COLS);

   always_comb begin
      case (req_action)
         mma_pkg::ACT_LOAD_S:   bad_in = !(col_ok && inner_ok);
         mma_pkg::ACT_STREAM_A: bad_in = !(row_ok && inner_ok);
         default:               bad_in = !(row_ok && col_ok);
      endcase
   end

   assign req_tready = (state_ff == mma_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ncols = (32'(cols_used_ff) > MAX_COLS) ? ColsCap : cols_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_used_ff  <= mma_pkg::ROWS_RESET;
         inner_used_ff <= mma_pkg::INNER_RESET;
         cols_used_ff  <= mma_pkg::COLS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mma_pkg::CSR_ROWS_USED:  rows_used_ff  <= csr_data;
            mma_pkg::CSR_INNER_USED: inner_used_ff <= csr_data;
            mma_pkg::CSR_COLS_USED:  cols_used_ff  <= csr_data[mma_pkg::COLS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   assign rsp_load = (state_ff == mma_pkg::ST_RESP) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mma_pkg::ST_IDLE: begin
            if (req_fire) state_in = mma_pkg::ST_EXEC;
         end
         mma_pkg::ST_EXEC: begin
            if (!bad_ff && action_ff == mma_pkg::ACT_STREAM_A && ncols != '0) begin
               state_in = mma_pkg::ST_MAC;
            end else if (!bad_ff && action_ff == mma_pkg::ACT_READ_ACC) begin
               state_in = mma_pkg::ST_DRAIN;
            end else begin
               state_in = mma_pkg::ST_RESP;
            end
         end
         mma_pkg::ST_MAC: begin
            if (cnt_ff == ncols - CntW'(1)) state_in = mma_pkg::ST_DRAIN;
         end
         mma_pkg::ST_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff && !rd_pend_ff) state_in = mma_pkg::ST_RESP;
         end
         mma_pkg::ST_RESP: begin
            if (rsp_load) state_in = mma_pkg::ST_IDLE;
         end
         default: state_in = mma_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mma_pkg::ST_IDLE;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= (state_ff == mma_pkg::ST_MAC);
         p2_valid_ff <= p1_valid_ff;
         rd_pend_ff  <= (state_ff == mma_pkg::ST_EXEC) && !bad_ff
                        && (action_ff == mma_pkg::ACT_READ_ACC);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= req_action;
         row_ff    <= req_row;
         inner_ff  <= req_inner;
         col_ff    <= req_col;
         value_ff  <= req_tdata[mma_pkg::VALUE_LSB +: mma_pkg::VALUE_W];
         bad_ff    <= bad_in;
      end
      if (state_ff == mma_pkg::ST_EXEC) begin
         cnt_ff <= '0;
      end else if (state_ff == mma_pkg::ST_MAC) begin
         cnt_ff <= cnt_ff + CntW'(1);
      end
      p1_col_ff  <= cnt_ff;
      p2_col_ff  <= p1_col_ff;
      p2_prod_ff <= value_ff * s_rd_data;
      p2_acc_ff  <= acc_rd_data;
      if (rd_pend_ff) begin
         rd_value_ff <= acc_rd_data;
      end
      if (rsp_load) begin
         rsp_bad_ff  <= bad_ff;
         rsp_data_ff <= (!bad_ff && action_ff == mma_pkg::ACT_READ_ACC) ? rd_value_ff : '0;
      end
   end

   // S memory: S loads write, the column loop reads S(c, inner)
   assign s_we      = (state_ff == mma_pkg::ST_EXEC) && !bad_ff
                      && (action_ff == mma_pkg::ACT_LOAD_S);
   assign s_wr_addr = SAW'(32'(col_ff) * MAX_INNER + 32'(inner_ff));
   assign s_re      = (state_ff == mma_pkg::ST_MAC);
   assign s_rd_addr = SAW'(32'(cnt_ff) * MAX_INNER + 32'(inner_ff));

   // Accumulator: loads and reads use (row, col); the column loop reads column c while column c-2 is written back
   assign acc_re      = (state_ff == mma_pkg::ST_MAC)
                        || ((state_ff == mma_pkg::ST_EXEC) && !bad_ff
                            && (action_ff == mma_pkg::ACT_READ_ACC));
   assign acc_rd_addr = (state_ff == mma_pkg::ST_MAC)
                        ? AccAW'(32'(row_ff) * MAX_COLS + 32'(cnt_ff))
                        : AccAW'(32'(row_ff) * MAX_COLS + 32'(col_ff));
   assign acc_we      = p2_valid_ff
                        || ((state_ff == mma_pkg::ST_EXEC) && !bad_ff
                            && (action_ff == mma_pkg::ACT_LOAD_ACC));
   assign acc_wr_addr = p2_valid_ff
                        ? AccAW'(32'(row_ff) * MAX_COLS + 32'(p2_col_ff))
                        : AccAW'(32'(row_ff) * MAX_COLS + 32'(col_ff));
   assign acc_wr_data = p2_valid_ff ? (p2_acc_ff + p2_prod_ff) : value_ff;

   mma_ram #(
      .WIDTH (mma_pkg::VALUE_W),
      .DEPTH (SDepth)
   ) u_s_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_wr_addr),
      .wr_data (value_ff),
      .rd_en   (s_re),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   mma_ram #(
      .WIDTH (mma_pkg::VALUE_W),
      .DEPTH (AccDepth)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_en   (acc_re),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;

   a_bad_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("flagged response carries nonzero data");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == mma_pkg::ST_EXEC)
      else $error("accepted beat did not start execution");

   a_resp_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == mma_pkg::ST_RESP |-> !p1_valid_ff && !p2_valid_ff && !rd_pend_ff)
      else $error("response issued with accumulator updates in flight");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == mma_pkg::ST_IDLE |-> !acc_we && !s_we)
      else $error("memory write while idle");

endmodule
